/* src/u8to16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8to16_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
    logic        text_end;
    logic        cut_short;
  } out_item_t;

  // Up to two units come out of one byte; n_units says how many are valid.
  typedef struct packed {
    logic [1:0] n_units;
    out_item_t  first;
    out_item_t  second;
  } dec_res_t;

  localparam logic [20:0] SurrogateLo  = 21'h00D800;
  localparam logic [20:0] SurrogateHi  = 21'h00DFFF;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [20:0] CodePointMax = 21'h10FFFF;
  localparam logic [15:0] Replacement  = 16'hFFFD;
  localparam logic [5:0]  HighSurTag   = 6'b110110;
  localparam logic [5:0]  LowSurTag    = 6'b110111;

endpackage

/* src/u8to16_decode.sv */
// Sequence decoder: holds the partial code point and turns a finished one into UTF-16 units.
module u8to16_decode
  import u8to16_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  output dec_res_t res_o
);

  logic [1:0]  pending_q, pending_d;
  logic [20:0] accum_q, accum_d;

  logic        done;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [7:0]  b;

  always_comb begin
    b         = item_i.text_byte;
    done      = 1'b0;
    cp        = '0;
    pending_d = pending_q;
    accum_d   = accum_q;
    res_o     = '0;
    cp_off    = '0;

    if (pending_q == 2'd0) begin
      if (!b[7]) begin
        cp   = {13'd0, b};
        done = 1'b1;
      end else if (!b[5]) begin
        accum_d   = {16'd0, b[4:0]};
        pending_d = 2'd1;
      end else if (!b[4]) begin
        accum_d   = {17'd0, b[3:0]};
        pending_d = 2'd2;
      end else begin
        accum_d   = {18'd0, b[2:0]};
        pending_d = 2'd3;
      end
    end else begin
      accum_d   = {accum_q[14:0], b[5:0]};
      pending_d = pending_q - 2'd1;
      if (pending_q == 2'd1) begin
        cp   = accum_d;
        done = 1'b1;
      end
    end

    if (!done) begin
      if (item_i.final_byte) begin
        // Text ended inside a sequence: one zero unit flagged as truncated.
        res_o.n_units = 2'd1;
        res_o.first   = '{code_unit: 16'd0, run_end: 1'b1, text_end: 1'b1,
                          cut_short: 1'b1};
        pending_d     = 2'd0;
        accum_d       = '0;
      end
    end else begin
      pending_d = 2'd0;
      accum_d   = '0;
      if (cp < SuppBase) begin
        res_o.n_units = 2'd1;
        res_o.first.code_unit = (cp >= SurrogateLo && cp <= SurrogateHi) ?
                                Replacement : cp[15:0];
        res_o.first.run_end   = 1'b1;
        res_o.first.text_end  = item_i.final_byte;
      end else if (cp <= CodePointMax) begin
        cp_off = cp - SuppBase;
        res_o.n_units = 2'd2;
        res_o.first.code_unit  = {HighSurTag, cp_off[19:10]};
        res_o.second.code_unit = {LowSurTag, cp_off[9:0]};
        res_o.second.run_end   = 1'b1;
        res_o.second.text_end  = item_i.final_byte;
      end else begin
        res_o.n_units = 2'd1;
        res_o.first.code_unit = Replacement;
        res_o.first.run_end   = 1'b1;
        res_o.first.text_end  = item_i.final_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      accum_q   <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      accum_q   <= accum_d;
    end
  end

endmodule

/* src/u8to16_fifo.sv */
// Small result queue that takes up to two units per cycle and hands out one.
module u8to16_fifo
  import u8to16_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dec_res_t  res_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output out_item_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  out_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_1, wr_2;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      n_push;
  logic            do_pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  always_comb begin
    n_push  = push_i ? res_i.n_units : 2'd0;
    do_pop  = pop_i && (count_q != '0);
    wr_1    = inc(wr_q);
    wr_2    = inc(wr_1);
    case (n_push)
      2'd1:    wr_d = wr_1;
      2'd2:    wr_d = wr_2;
      default: wr_d = wr_q;
    endcase
    rd_d    = do_pop ? inc(rd_q) : rd_q;
    count_d = count_q + CntW'(n_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= res_i.first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_1] <= res_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  assign room_o  = (count_q <= CntW'(Depth - 2));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

/* src/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder and result queue.
//
// The input channel carries one UTF-8 byte per transaction plus a flag for the last
// byte of the text. The output channel carries one UTF-16 code unit per transaction,
// with flags for the last unit caused by a byte, the last unit of the text, and the
// zero unit emitted when the text ends inside an open sequence.
// Both channels use valid/stall: a transaction completes on a rising edge with valid
// high and stall low. An accepted byte is held in the input register, is decoded
// there and its units are written into a queue of Depth entries; the earliest unit
// is offered on the output from the queue, so the input register and the queue lie
// between acceptance and output. The decoder moves a byte on only when the queue has
// room for two units, so one byte per cycle is sustained as long as the output drains
// one unit per cycle; supplementary characters give two units and so two output transactions.
// When the receiver stalls, the queue fills and the input register holds its byte and
// raises in_stall_o; nothing is lost or repeated. Reset clears the open sequence, the
// queue and the input register; after the final byte of a text the decoder returns to
// its reset state so that a new text can follow directly.
module utf8_to_utf16_transcoder
  import u8to16_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  // Input register.
  logic     in_valid_q;
  in_item_t in_item_q;

  logic     room;
  logic     dec_fire;
  dec_res_t dec_res;

  // The held byte is decoded once the queue can take a full surrogate pair.
  assign dec_fire   = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  u8to16_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (dec_fire),
    .item_i (in_item_q),
    .res_o  (dec_res)
  );

  u8to16_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec_fire),
    .res_i   (dec_res),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // A byte held back by a full queue stays in the input register unchanged.
  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_item_q))
    else $error("input register lost a stalled byte");

  // The truncation unit is always zero and closes both the byte and the text.
  a_cut_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cut_short |->
      out_data_o.code_unit == 16'd0 && out_data_o.run_end && out_data_o.text_end)
    else $error("malformed truncation unit");

  // A unit that does not end its byte is the high half of a surrogate pair.
  a_pair_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_end |->
      out_data_o.code_unit[15:10] == HighSurTag && !out_data_o.text_end &&
      !out_data_o.cut_short)
    else $error("first unit of a pair is not a high surrogate");

  // The unit following a high surrogate is its low surrogate.
  a_pair_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_end |=>
      out_valid_o && out_data_o.run_end && out_data_o.code_unit[15:10] == LowSurTag)
    else $error("high surrogate not followed by its low surrogate");

endmodule
